// ===== rtl/mie_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mie_pkg: shared types and constants of the modular inverse unit
// Holds field widths, the transaction structs and the divider handshake.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int WIDTH = 32;
  localparam int FW    = WIDTH - 1;          // field width
  localparam int CW    = WIDTH + 1;          // signed coefficient width
  localparam int DCNT_W = $clog2(FW);        // divider step counter

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_COPRIME = 2'd1,
    ST_ZERO_MOD    = 2'd2
  } mie_status_e;

  typedef struct packed {
    logic [FW-1:0] value;
    logic [FW-1:0] modulus;
  } mie_in_t;

  typedef struct packed {
    logic [FW-1:0] inverse;
    logic [FW-1:0] divisor;
    mie_status_e   status;
  } mie_out_t;

  typedef struct packed {
    logic          start;
    logic [FW-1:0] dividend;
    logic [FW-1:0] divisor;
  } mie_div_req_t;

  typedef struct packed {
    logic          done;
    logic          busy;
    logic [FW-1:0] quo;
    logic [FW-1:0] rem;
  } mie_div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/mie_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mie_divider: iterative restoring divider
// One quotient bit per cycle; done pulses once quotient and remainder hold.
// ----------------------------------------------------------------------------
module mie_divider
  import mie_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire mie_div_req_t req_i,
  output mie_div_rsp_t      rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [FW:0]       rem_q, rem_d;
  logic [FW-1:0]     quo_q, quo_d;
  logic [FW-1:0]     dsr_q, dsr_d;
  logic [FW:0]       shifted;
  logic [FW+1:0]     diff;

  always_comb begin
    shifted = {rem_q[FW-1:0], quo_q[FW-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      // keep the difference unless it borrowed
      if (diff[FW+1]) begin
        rem_d = shifted;
        quo_d = {quo_q[FW-2:0], 1'b0};
      end else begin
        rem_d = diff[FW:0];
        quo_d = {quo_q[FW-2:0], 1'b1};
      end
      cnt_d = cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(FW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q[FW-1:0];

endmodule
`default_nettype wire

// ===== rtl/modular_inverse_ext_euclid_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_unit: modular inverse by extended Euclid
// Runs Euclid rounds on a shared divider, tracks the Bezout coefficient of
// value and reports inverse, gcd and status.
// ----------------------------------------------------------------------------
//
//  channel | ports                    | handshake
//  --------+--------------------------+------------------------------------
//  input   | in_i (value, modulus)    | taken when start_i high, busy_o low
//  result  | out_o (inverse, divisor, | done_o high one cycle; no stall
//          |   status)                |
//
// Each Euclid round runs a check state, a division in the shared restoring
// divider (one quotient bit per cycle), a multiply state and a coefficient
// update state. An item runs at most about 46 rounds for 31-bit operands;
// a zero modulus goes straight from the check state to the finishing state.
// busy_o is high from the accepting edge until the result cycle; a new
// transaction may be started in the cycle done_o is high.
// Reset clears the sequencer and the divider control; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_unit
  import mie_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  output logic         busy_o,
  input  wire mie_in_t in_i,
  output logic         done_o,
  output mie_out_t     out_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_UPD  = 6'b010000,
    S_FIN  = 6'b100000
  } mie_state_e;

  mie_state_e    state_q, state_d;
  logic          done_q, done_d;
  mie_out_t      out_q, out_d;

  // Euclid working registers
  logic [FW-1:0] mod_q, mod_d;
  logic [FW-1:0] dvd_q, dvd_d;      // current dividend, ends as the gcd
  logic [FW-1:0] dsr_q, dsr_d;      // current divisor
  logic [FW-1:0] quo_q, quo_d;
  logic [FW-1:0] rem_q, rem_d;
  logic [CW-1:0] c_old_q, c_old_d;  // two's complement coefficients
  logic [CW-1:0] c_new_q, c_new_d;
  logic [CW-1:0] prod_q, prod_d;

  logic [CW-1:0]   prod_full;       // low bits only: coefficients wrap at CW
  logic [CW-1:0]   inv_fix;
  logic            accept;

  mie_div_req_t div_req;
  mie_div_rsp_t div_rsp;

  mie_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign accept    = start_i && (state_q == S_IDLE);
  assign prod_full = {{(CW-FW){1'b0}}, quo_q} * c_new_q;
  // add the modulus back when the coefficient went negative
  assign inv_fix   = c_old_q[CW-1] ? (c_old_q + {{(CW-FW){1'b0}}, mod_q}) : c_old_q;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    out_d   = out_q;
    mod_d   = mod_q;
    dvd_d   = dvd_q;
    dsr_d   = dsr_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    c_old_d = c_old_q;
    c_new_d = c_new_q;
    prod_d  = prod_q;

    div_req.start    = 1'b0;
    div_req.dividend = dvd_q;
    div_req.divisor  = dsr_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mod_d   = in_i.modulus;
          dvd_d   = in_i.value;
          dsr_d   = in_i.modulus;
          c_old_d = CW'(1);
          c_new_d = '0;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        // stop once the divisor has run down to zero
        if (dsr_q == '0) begin
          state_d = S_FIN;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          quo_d   = div_rsp.quo;
          rem_d   = div_rsp.rem;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = prod_full;
        state_d = S_UPD;
      end
      S_UPD: begin
        c_old_d = c_new_q;
        c_new_d = c_old_q - prod_q;
        dvd_d   = dsr_q;
        dsr_d   = rem_q;
        state_d = S_CHK;
      end
      S_FIN: begin
        done_d = 1'b1;
        out_d.divisor = dvd_q;
        if (mod_q == '0) begin
          out_d.inverse = '0;
          out_d.status  = ST_ZERO_MOD;
        end else begin
          out_d.inverse = inv_fix[FW-1:0];
          out_d.status  = (dvd_q == FW'(1)) ? ST_OK : ST_NOT_COPRIME;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    mod_q   <= mod_d;
    dvd_q   <= dvd_d;
    dsr_q   <= dsr_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    c_old_q <= c_old_d;
    c_new_q <= c_new_d;
    prod_q  <= prod_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign out_o  = out_q;

  // a result follows only the finishing state
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_FIN))
    else $error("result strobe without finishing state");

  // the divider only runs while the sequencer waits on it
  a_div_busy_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == S_DIV))
    else $error("divider busy outside divide state");

  // ok status means the gcd is one
  a_ok_gcd_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && out_q.status == ST_OK) |-> (out_q.divisor == FW'(1)))
    else $error("ok status with gcd other than one");

  // zero modulus reports a zero inverse
  a_zero_mod_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && out_q.status == ST_ZERO_MOD) |-> (out_q.inverse == '0))
    else $error("zero modulus with nonzero inverse");

endmodule
`default_nettype wire

// ===== tb/modular_inverse_ext_euclid_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_unit_tb: self-checking bench of the inverse unit
// Sends directed and random (value, modulus) transactions, predicts inverse,
// gcd and status with an in-bench extended Euclid, and checks every result.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_unit_tb;
  import mie_pkg::*;

  // One item needs at most about 46 Euclid rounds; allow several times the
  // slowest run of all items back to back.
  localparam int LIMIT_CYCLES   = 3_000_000;
  localparam int DRAIN_CYCLES   = 1700;
  localparam int RANDOM_ITEMS   = 400;
  localparam int QUIET_TAIL     = 40;    // last random items sent without idling
  localparam int MAX_PRINTS     = 100;

  localparam logic [FW-1:0] FIELD_MAX = '1;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts each accepted transaction and checks results in order
  // --------------------------------------------------------------------------
  class inverse_scoreboard;
    mie_out_t pending_results[$];
    int       mismatch_count = 0;

    // Extended Euclid on 64-bit words; the coefficient sign lives in bit 63.
    function mie_out_t predict_inverse(mie_in_t item);
      logic [63:0] dvd, dvs, c_old, c_new, quo, rem, nxt, md;
      mie_out_t    res;
      dvd = '0;
      md  = '0;
      dvd[FW-1:0] = item.value;
      md[FW-1:0]  = item.modulus;
      if (md == 64'd0) begin
        res.inverse = '0;
        res.divisor = item.value;
        res.status  = ST_ZERO_MOD;
        return res;
      end
      dvs   = md;
      c_old = 64'd1;
      c_new = 64'd0;
      while (dvs != 64'd0) begin
        quo   = dvd / dvs;
        rem   = dvd % dvs;
        nxt   = c_old - quo * c_new;
        dvd   = dvs;
        dvs   = rem;
        c_old = c_new;
        c_new = nxt;
      end
      if (c_old[63])
        c_old = c_old + md;
      res.inverse = c_old[FW-1:0];
      res.divisor = dvd[FW-1:0];
      res.status  = (dvd == 64'd1) ? ST_OK : ST_NOT_COPRIME;
      return res;
    endfunction

    task report_mismatch(string what);
      if (mismatch_count < MAX_PRINTS)
        $display("tb: mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
    endtask

    function void note_request(mie_in_t item);
      pending_results.push_back(predict_inverse(item));
    endfunction

    task check_response(mie_out_t got);
      mie_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result inverse=%h divisor=%h status=%0d",
                                  got.inverse, got.divisor, got.status));
        return;
      end
      want = pending_results.pop_front();
      if (got.inverse !== want.inverse)
        report_mismatch($sformatf("inverse %h, expected %h", got.inverse, want.inverse));
      if (got.divisor !== want.divisor)
        report_mismatch($sformatf("divisor %h, expected %h", got.divisor, want.divisor));
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  mie_in_t  in_i    = '0;
  logic     busy_o;
  logic     done_o;
  mie_out_t out_o;

  inverse_scoreboard sb;
  int unsigned       cycle_count = 0;
  logic [63:0]       fib_table[0:47];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  modular_inverse_ext_euclid_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .in_i   (in_i),
    .done_o (done_o),
    .out_o  (out_o)
  );

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Full-width random field; every bit is equally likely to be 0 or 1.
  function automatic logic [FW-1:0] rand_field();
    logic [63:0] word;
    word = {$urandom(), $urandom()};
    return word[FW-1:0];
  endfunction

  function automatic mie_in_t make_item(logic [63:0] v, logic [63:0] m);
    mie_in_t item;
    item.value   = v[FW-1:0];
    item.modulus = m[FW-1:0];
    return item;
  endfunction

  // Mostly well-formed inverse queries, with degenerate and broken pairs mixed in.
  function automatic mie_in_t random_item();
    logic [63:0] v, m, g;
    int          k;
    v = '0;
    m = '0;
    case ($urandom_range(0, 11))
      0, 1: begin
        // Any pair at all.
        v[FW-1:0] = rand_field();
        m[FW-1:0] = rand_field();
      end
      2, 3: begin
        // Value reduced below the modulus, the usual use of the block.
        m[FW-1:0] = rand_field();
        if (m == 64'd0) m = 64'd1;
        v[FW-1:0] = rand_field();
        v = v % m;
      end
      4: begin
        // Prime moduli: every nonzero value below has an inverse.
        case ($urandom_range(0, 4))
          0: m = 64'd2147483647;
          1: m = 64'd1000000007;
          2: m = 64'd65521;
          3: m = 64'd97;
          default: m = 64'd2;
        endcase
        m = m & 64'(FIELD_MAX);
        v[FW-1:0] = rand_field();
      end
      5: begin
        // Shared factor: no inverse, gcd above one.
        g = 64'($urandom_range(2, 1000));
        v = g * 64'($urandom_range(0, 2_000_000));
        m = g * 64'($urandom_range(1, 2_000_000));
      end
      6: begin
        // Short operands, few rounds.
        v = 64'($urandom_range(0, 255));
        m = 64'($urandom_range(0, 255));
      end
      7: begin
        // Consecutive Fibonacci numbers run the most rounds.
        k = $urandom_range(1, 45);
        if ($urandom_range(0, 1) == 1) begin
          v = fib_table[k+1];
          m = fib_table[k];
        end else begin
          v = fib_table[k];
          m = fib_table[k+1];
        end
      end
      8: begin
        // Near the top of the field range.
        v = 64'(FIELD_MAX) - 64'($urandom_range(0, 15));
        m = 64'(FIELD_MAX) - 64'($urandom_range(0, 15));
      end
      9: begin
        // Zero modulus.
        v[FW-1:0] = rand_field();
        m = 64'd0;
      end
      10: begin
        // Zero value.
        v = 64'd0;
        m[FW-1:0] = rand_field();
      end
      default: begin
        // Modulus one.
        v[FW-1:0] = rand_field();
        m = 64'd1;
      end
    endcase
    return make_item(v, m);
  endfunction

  // Drive one transaction; hold start until the block takes it.
  task automatic drive_request(input mie_in_t item, input bit may_idle);
    int gap;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      start_i <= 1'b0;
      in_i    <= {rand_field(), rand_field()};   // noise while start is low
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= item;
    @(posedge clk_i);
    // Values read here are the ones before the edge: busy low means taken.
    while (busy_o) @(posedge clk_i);
    sb.note_request(item);
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: a strobe lasts one cycle, so sample at every edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_response(out_o);
  end

  // --------------------------------------------------------------------------
  // Watchdog: count cycles and end the run if it hangs
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mie_in_t directed[$];
    logic [63:0] fmax;
    sb = new();
    fmax = 64'(FIELD_MAX);

    fib_table[0] = 64'd0;
    fib_table[1] = 64'd1;
    for (int i = 2; i < 48; i++)
      fib_table[i] = fib_table[i-1] + fib_table[i-2];

    // Directed pairs: field extremes, zero modulus, zero value, modulus one,
    // no inverse, the longest Fibonacci chain and alternating bit patterns.
    directed.push_back(make_item(64'd0, 64'd0));
    directed.push_back(make_item(fmax, 64'd0));
    directed.push_back(make_item(64'd5, 64'd0));
    directed.push_back(make_item(64'd0, 64'd1));
    directed.push_back(make_item(fmax, 64'd1));
    directed.push_back(make_item(64'd1, 64'd1));
    directed.push_back(make_item(64'd0, fmax));
    directed.push_back(make_item(64'd0, 64'd12));
    directed.push_back(make_item(64'd1, fmax));
    directed.push_back(make_item(fmax, fmax));
    directed.push_back(make_item(fmax - 1, fmax));
    directed.push_back(make_item(fmax, fmax - 1));
    directed.push_back(make_item(64'd3, 64'd7));
    directed.push_back(make_item(64'd7, 64'd3));
    directed.push_back(make_item(64'd6, 64'd9));
    directed.push_back(make_item(64'd2, fmax - 1));
    directed.push_back(make_item(64'd12345, 64'd1000000007));
    directed.push_back(make_item(fib_table[46], fib_table[45]));
    directed.push_back(make_item(fib_table[45], fib_table[46]));
    directed.push_back(make_item(64'h2AAA_AAAA, 64'h5555_5555));
    directed.push_back(make_item(64'h5555_5555, 64'h2AAA_AAAA));

    // Hold reset, then release it once for the whole run.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i])
      drive_request(directed[i], 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++)
      drive_request(random_item(), i < RANDOM_ITEMS - QUIET_TAIL);

    start_i <= 1'b0;

    // Wait out every outstanding result, then watch for strays.
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
